### rtl/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int DATA_W = 32;
    localparam int PRI_W  = 16;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;

    // one stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic signed [PRI_W-1:0]  rank;
    } entry_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t item;
    } spq_ctl_t;

endpackage

### rtl/spq_in_if.sv
interface spq_in_if;
    logic                                valid;
    logic                                ready;
    logic [spq_pkg::CMD_W-1:0]           command;
    logic signed [spq_pkg::DATA_W-1:0]   in_data;
    logic signed [spq_pkg::PRI_W-1:0]    in_priority;

    modport source (output valid, command, in_data, in_priority, input ready);
    modport sink   (input valid, command, in_data, in_priority, output ready);
endinterface

### rtl/spq_out_if.sv
interface spq_out_if;
    logic                                valid;
    logic                                ready;
    logic [spq_pkg::STAT_W-1:0]          status;
    logic signed [spq_pkg::DATA_W-1:0]   out_data;
    logic signed [spq_pkg::PRI_W-1:0]    out_priority;
    logic [spq_pkg::OCC_W-1:0]           occupancy;

    modport source (output valid, status, out_data, out_priority, occupancy,
                    input ready);
    modport sink   (input valid, status, out_data, out_priority, occupancy,
                    output ready);
endinterface

### rtl/spq_cell.sv
module spq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  spq_pkg::spq_ctl_t ctl,
    input  spq_pkg::entry_t   left_entry,
    input  logic              left_valid,
    input  logic              left_gt,
    input  spq_pkg::entry_t   right_entry,
    input  logic              right_valid,
    output spq_pkg::entry_t   entry,
    output logic              valid,
    output logic              gt
);

    spq_pkg::entry_t entry_reg, entry_next;
    logic            valid_reg, valid_next;

    // empty slot or strictly larger rank: new item goes at or before here
    assign gt = !valid_reg || (entry_reg.rank > ctl.item.rank);

    // shift right on insert, shift left on remove
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctl.push && gt)
        begin
            if (left_gt)
            begin
                entry_next = left_entry;
                valid_next = left_valid;
            end
            else
            begin
                entry_next = ctl.item;
                valid_next = 1'b1;
            end
        end
        else if (ctl.pop)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

### rtl/stable_min_priority_queue.sv
// Stable minimum priority queue, sorted chain of CAPACITY cells.
// req channel (sink): command, in_data, in_priority. Enqueue inserts the word
//   after every stored entry of equal or smaller priority; dequeue removes and
//   returns the head; peek returns the head and keeps it. Code 3 is a no-op.
// rsp channel (source): status, out_data, out_priority, occupancy; one word
//   for every accepted request. Underflow on dequeue/peek of an empty queue,
//   overflow (word dropped) on enqueue into a full queue.
// Latency: the response is registered and valid the cycle after acceptance.
// Throughput: one request per cycle while the response register is empty or being
//   taken; every cell compares its rank with the new priority in parallel and
//   shifts toward its neighbor in the same cycle.
// Stall: the response register holds while rsp.ready is low; req.ready stays
//   high as long as the response register is empty or being taken.
// Reset: all cell valid bits and the count clear, queue is empty, no
//   response pending. Payload registers are not reset.
module stable_min_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_in_if.sink    req,
    spq_out_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    spq_pkg::spq_ctl_t ctl;
    spq_pkg::entry_t   cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_gt;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             accept, full, empty;

    logic                                rsp_valid_reg;
    logic [spq_pkg::STAT_W-1:0]          status_reg, status_next;
    logic signed [spq_pkg::DATA_W-1:0]   data_reg, data_next;
    logic signed [spq_pkg::PRI_W-1:0]    pri_reg, pri_next;
    logic [spq_pkg::OCC_W-1:0]           occ_reg, occ_next;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    // decode command into chain control
    always_comb
    begin
        ctl.push      = accept && (req.command == spq_pkg::CMD_ENQUEUE) && !full;
        ctl.pop       = accept && (req.command == spq_pkg::CMD_DEQUEUE) && !empty;
        ctl.item.data = req.in_data;
        ctl.item.rank = req.in_priority;
    end

    // cell chain, head at index 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_pkg::entry_t l_entry, r_entry;
        logic            l_valid, l_gt, r_valid;

        if (i == 0)
        begin : g_head
            assign l_entry = ctl.item;
            assign l_valid = 1'b0;
            assign l_gt    = 1'b0;
        end
        else
        begin : g_mid
            assign l_entry = cell_entry[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_gt    = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign r_entry = ctl.item;
            assign r_valid = 1'b0;
        end
        else
        begin : g_body
            assign r_entry = cell_entry[i+1];
            assign r_valid = cell_valid[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .left_entry  (l_entry),
            .left_valid  (l_valid),
            .left_gt     (l_gt),
            .right_entry (r_entry),
            .right_valid (r_valid),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i])
        );
    end

    // occupancy and response word
    always_comb
    begin
        count_next  = count_reg;
        status_next = spq_pkg::ST_OK;
        data_next   = '0;
        pri_next    = '0;
        case (req.command)
            spq_pkg::CMD_ENQUEUE:
            begin
                if (full)
                    status_next = spq_pkg::ST_OVERFLOW;
                else
                    count_next = count_reg + 1'b1;
            end
            spq_pkg::CMD_DEQUEUE, spq_pkg::CMD_PEEK:
            begin
                if (empty)
                    status_next = spq_pkg::ST_UNDERFLOW;
                else
                begin
                    data_next = cell_entry[0].data;
                    pri_next  = cell_entry[0].rank;
                    if (req.command == spq_pkg::CMD_DEQUEUE)
                        count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        occ_next = spq_pkg::OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
            pri_reg    <= pri_next;
            occ_reg    <= occ_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_data     = data_reg;
    assign rsp.out_priority = pri_reg;
    assign rsp.occupancy    = occ_reg;

`ifndef SYNTHESIS
    // valid cells match the count
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("cell valid bits disagree with count");

    // head two entries stay ordered
    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> (cell_entry[0].rank <= cell_entry[1].rank))
        else $error("chain head out of order");

    // dequeue of a non-empty queue shrinks it by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("dequeue did not decrement count");

    // enqueue into a full queue reports overflow and keeps count
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.command == spq_pkg::CMD_ENQUEUE && full) |=>
        (rsp.status == spq_pkg::ST_OVERFLOW && $stable(count_reg)))
        else $error("overflow not reported");
`endif

endmodule

### tb/sv/tb_stable_min_priority_queue.sv
`timescale 1ns / 100ps

module tb_stable_min_priority_queue;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = CAPACITY_DEFAULT;
    localparam int RANDOM_WORDS = 500;
    localparam int MAX_GAP      = 10;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AT      = 150;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int PRINT_LIMIT  = 30;

    // code 3 is not named in the package; the block treats it as a no-op
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    localparam logic signed [PRI_W-1:0]  PRI_MIN  = {1'b1, {(PRI_W-1){1'b0}}};
    localparam logic signed [PRI_W-1:0]  PRI_MAX  = {1'b0, {(PRI_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [DATA_W-1:0]  payload;
        logic signed [PRI_W-1:0]   pri;
    } req_word_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [DATA_W-1:0]  payload;
        logic signed [PRI_W-1:0]   pri;
        logic [OCC_W-1:0]          occupancy;
    } rsp_word_t;

    logic clk;
    logic rst_n;

    spq_in_if  req_if ();
    spq_out_if rsp_if ();

    stable_min_priority_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    req_word_t pending_words[$];
    rsp_word_t expected_responses[$];
    entry_t    sorted_entries[$];

    logic req_fire;
    logic rsp_fire;
    int   queued_words;
    int   sent_words;
    int   taken_responses;
    int   error_count;
    int   cycle_count;
    int   send_wait;
    int   recv_wait;
    int   hold_left;
    bit   hold_done;

    // coverage tallies for the closing summary
    int enqueue_count;
    int overflow_count;
    int remove_count;
    int underflow_count;
    int nop_count;
    int deepest_fill;

    // clock and the single reset at the start
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        fork
            forever #5 clk = ~clk;
        join_none
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    function automatic int pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // ties near zero, the extremes, or anything in range
    function automatic logic signed [PRI_W-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0: return PRI_W'(int'($urandom_range(0, 6)) - 3);
            1: return $urandom_range(0, 1) ? PRI_MAX : PRI_MIN;
            default: return PRI_W'($urandom);
        endcase
    endfunction

    task automatic queue_word(input logic [CMD_W-1:0] cmd,
                              input logic signed [DATA_W-1:0] value,
                              input logic signed [PRI_W-1:0] pri);
        req_word_t w;
        w.command = cmd;
        w.payload = value;
        w.pri = pri;
        pending_words.push_back(w);
        if (cmd != CMD_NOP)
            queued_words++;
    endtask

    // sorted-list behavior: insert after equal ranks, take from the head
    function automatic rsp_word_t predict_response(input req_word_t w);
        rsp_word_t r;
        entry_t    e;
        int        pos;
        r = '0;
        r.status = ST_OK;
        case (w.command)
            CMD_ENQUEUE:
            begin
                if (sorted_entries.size() >= QUEUE_DEPTH)
                    r.status = ST_OVERFLOW;
                else
                begin
                    pos = 0;
                    while (pos < sorted_entries.size() &&
                           $signed(sorted_entries[pos].rank) <= $signed(w.pri))
                        pos++;
                    e.data = w.payload;
                    e.rank = w.pri;
                    sorted_entries.insert(pos, e);
                end
            end
            CMD_DEQUEUE, CMD_PEEK:
            begin
                if (sorted_entries.size() == 0)
                    r.status = ST_UNDERFLOW;
                else
                begin
                    r.payload = sorted_entries[0].data;
                    r.pri = sorted_entries[0].rank;
                    if (w.command == CMD_DEQUEUE)
                        void'(sorted_entries.pop_front());
                end
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(sorted_entries.size());
        return r;
    endfunction

    // request side: note each accepted word and predict its response
    always @(posedge clk)
    begin : req_capture
        req_word_t seen;
        rsp_word_t want;
        if (!rst_n)
            req_fire <= 1'b0;
        else
        begin
            req_fire <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready)
            begin
                seen.command = req_if.command;
                seen.payload = req_if.in_data;
                seen.pri = req_if.in_priority;
                want = predict_response(seen);
                expected_responses.push_back(want);
                sent_words++;
                case (seen.command)
                    CMD_ENQUEUE:
                    begin
                        enqueue_count++;
                        if (want.status == ST_OVERFLOW)
                            overflow_count++;
                    end
                    CMD_DEQUEUE, CMD_PEEK:
                    begin
                        remove_count++;
                        if (want.status == ST_UNDERFLOW)
                            underflow_count++;
                    end
                    default: nop_count++;
                endcase
                if (int'(want.occupancy) > deepest_fill)
                    deepest_fill = int'(want.occupancy);
            end
        end
    end

    // request driver: hold a word until taken, then wait a drawn gap
    always @(negedge clk)
    begin : req_driver
        logic offer;
        offer = 1'b0;
        if (rst_n)
        begin
            if (req_fire)
            begin
                void'(pending_words.pop_front());
                send_wait = pick_gap((sent_words / 60) % 3 == 1);
            end
            if (req_if.valid && !req_fire)
                offer = 1'b1;
            else if (send_wait > 0)
                send_wait--;
            else
                offer = pending_words.size() != 0;
        end
        req_if.valid <= offer;
        if (offer)
        begin
            req_if.command <= pending_words[0].command;
            req_if.in_data <= pending_words[0].payload;
            req_if.in_priority <= pending_words[0].pri;
        end
    end

    // response side: compare each taken word with the oldest prediction
    always @(posedge clk)
    begin : rsp_monitor
        rsp_word_t want;
        if (!rst_n)
            rsp_fire <= 1'b0;
        else
        begin
            rsp_fire <= rsp_if.valid && rsp_if.ready;
            if (rsp_if.valid && rsp_if.ready)
            begin
                taken_responses++;
                if (expected_responses.size() == 0)
                    report_mismatch($sformatf("response word %0d with nothing outstanding",
                                              taken_responses));
                else
                begin
                    want = expected_responses.pop_front();
                    if (rsp_if.status !== want.status)
                        report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                                  taken_responses, rsp_if.status,
                                                  want.status));
                    if (rsp_if.out_data !== want.payload)
                        report_mismatch($sformatf("word %0d out_data %0d, expected %0d",
                                                  taken_responses, rsp_if.out_data,
                                                  want.payload));
                    if (rsp_if.out_priority !== want.pri)
                        report_mismatch($sformatf("word %0d out_priority %0d, expected %0d",
                                                  taken_responses, rsp_if.out_priority,
                                                  want.pri));
                    if (rsp_if.occupancy !== want.occupancy)
                        report_mismatch($sformatf("word %0d occupancy %0d, expected %0d",
                                                  taken_responses, rsp_if.occupancy,
                                                  want.occupancy));
                end
            end
        end
    end

    // response ready: drawn stalls, plus one long hold-off to back up the input
    always @(negedge clk)
    begin : rsp_driver
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            if (rsp_fire)
                recv_wait = pick_gap((taken_responses / 45) % 3 == 2);
            if (!hold_done && taken_responses >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still outstanding",
                     cycle_count, expected_responses.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int directed_words;
        int burst;
        int pick;
        int drain_cycles;

        // empty queue: peek, dequeue, no-op
        queue_word(CMD_PEEK, DATA_MAX, PRI_MAX);
        queue_word(CMD_DEQUEUE, DATA_MIN, PRI_MIN);
        queue_word(CMD_NOP, '1, '1);
        // field extremes and equal priorities that must leave in arrival order
        queue_word(CMD_ENQUEUE, DATA_MAX, PRI_MAX);
        queue_word(CMD_ENQUEUE, DATA_MIN, PRI_MIN);
        queue_word(CMD_ENQUEUE, '0, '0);
        queue_word(CMD_ENQUEUE, '1, '1);
        queue_word(CMD_ENQUEUE, 32'sd5, '0);
        queue_word(CMD_ENQUEUE, 32'sd6, '0);
        queue_word(CMD_ENQUEUE, 32'sd7, PRI_MIN);
        queue_word(CMD_ENQUEUE, 32'sd8, PRI_MAX);
        queue_word(CMD_PEEK, '0, '0);
        queue_word(CMD_NOP, '0, '0);
        repeat (8) queue_word(CMD_DEQUEUE, '0, '0);
        queue_word(CMD_DEQUEUE, '1, '1);
        directed_words = queued_words;

        // random bursts: fills run into overflow, drains into underflow
        while (queued_words - directed_words < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    burst = $urandom_range(4, 20);
                    repeat (burst) queue_word(CMD_ENQUEUE, $urandom, pick_priority());
                end
                1:
                begin
                    burst = $urandom_range(4, 20);
                    repeat (burst)
                        queue_word($urandom_range(0, 3) == 0 ? CMD_PEEK : CMD_DEQUEUE,
                                   $urandom, pick_priority());
                end
                default:
                begin
                    burst = $urandom_range(5, 30);
                    repeat (burst)
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 5)
                            queue_word(CMD_ENQUEUE, $urandom, pick_priority());
                        else if (pick < 8)
                            queue_word(CMD_DEQUEUE, $urandom, pick_priority());
                        else if (pick < 9)
                            queue_word(CMD_PEEK, $urandom, pick_priority());
                        else
                            queue_word(CMD_NOP, $urandom, pick_priority());
                    end
                end
            endcase
        end

        // let every word go in, then drain the responses
        @(posedge clk);
        while (pending_words.size() != 0 || req_if.valid)
            @(posedge clk);
        drain_cycles = 0;
        while (expected_responses.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (4) @(posedge clk);
        if (expected_responses.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived",
                                      expected_responses.size()));

        $display("Run covered %0d words: %0d enqueues (%0d dropped on a full queue),",
                 sent_words, enqueue_count, overflow_count);
        $display("  %0d dequeues/peeks (%0d on an empty queue), %0d no-ops, peak fill %0d",
                 remove_count, underflow_count, nop_count, deepest_fill);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/spq_pkg.sv
rtl/spq_in_if.sv
rtl/spq_out_if.sv
rtl/spq_cell.sv
rtl/stable_min_priority_queue.sv
tb/sv/tb_stable_min_priority_queue.sv
